// File: src/mbe_pkg.sv
// Package for the multibrot escape iteration block.
// Number format, saturating add/sub, sequencer states and register codes.
// No dependencies.
package mbe_pkg;

  // Fixed-point value format (two's complement, four integer bits incl. sign)
  localparam int VALUE_BITS = 64;
  localparam int FRAC_BITS  = VALUE_BITS - 4;
  localparam int MAX_POWER  = 16;

  // Port widths
  localparam int IO_W   = 64;
  localparam int CNT_W  = 16;
  localparam int POW_W  = 5;
  localparam int RAD_W  = 63;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = RAD_W;

  // Multiplier widths: magnitudes split into two halves
  localparam int MAG_W  = 64;
  localparam int HALF_W = MAG_W / 2;
  localparam int PROD_W = 2 * MAG_W;

  // Exponent counter width
  localparam int KW = $clog2(MAX_POWER + 1);

  // Compare width for |z|^2 against the radius
  localparam int CMP_W = ((VALUE_BITS > RAD_W) ? VALUE_BITS : RAD_W) + 2;

  typedef logic signed [VALUE_BITS-1:0] val_t;

  localparam val_t VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_SQ  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER      = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL_RR,
    ST_MUL_II,
    ST_ESC,
    ST_MUL_ZIZR,
    ST_PI_DBL,
    ST_LOOP_CHK,
    ST_MUL_T3,
    ST_MUL_T4,
    ST_MUL_PR,
    ST_MUL_PI,
    ST_COMB,
    ST_UPD,
    ST_FIN
  } state_t;

  // Saturating add
  function automatic val_t sat_add(val_t a, val_t b);
    logic signed [VALUE_BITS:0] s;
    s = {a[VALUE_BITS-1], a} + {b[VALUE_BITS-1], b};
    if (s[VALUE_BITS] != s[VALUE_BITS-1]) begin
      sat_add = s[VALUE_BITS] ? VAL_MIN : VAL_MAX;
    end else begin
      sat_add = s[VALUE_BITS-1:0];
    end
  endfunction

  // Saturating subtract
  function automatic val_t sat_sub(val_t a, val_t b);
    logic signed [VALUE_BITS:0] s;
    s = {a[VALUE_BITS-1], a} - {b[VALUE_BITS-1], b};
    if (s[VALUE_BITS] != s[VALUE_BITS-1]) begin
      sat_sub = s[VALUE_BITS] ? VAL_MIN : VAL_MAX;
    end else begin
      sat_sub = s[VALUE_BITS-1:0];
    end
  endfunction

endpackage

// File: src/mbe_in_if.sv
// Input channel of the multibrot escape iteration block: one point per item.
// Depends on mbe_pkg for widths.
interface mbe_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [mbe_pkg::IO_W-1:0]   c_real;
  logic signed [mbe_pkg::IO_W-1:0]   c_imag;
  logic signed [mbe_pkg::IO_W-1:0]   z_real_start;
  logic signed [mbe_pkg::IO_W-1:0]   z_imag_start;
  logic        [mbe_pkg::CNT_W-1:0]  count_start;

  modport source (
    output valid, c_real, c_imag, z_real_start, z_imag_start, count_start,
    input  ready
  );
  modport sink (
    input  valid, c_real, c_imag, z_real_start, z_imag_start, count_start,
    output ready
  );
endinterface

// File: src/mbe_out_if.sv
// Result channel of the multibrot escape iteration block: final count and z.
// Depends on mbe_pkg for widths.
interface mbe_out_if;
  logic                              valid;
  logic                              ready;
  logic        [mbe_pkg::CNT_W-1:0]  final_count;
  logic signed [mbe_pkg::IO_W-1:0]   z_real_final;
  logic signed [mbe_pkg::IO_W-1:0]   z_imag_final;

  modport source (
    output valid, final_count, z_real_final, z_imag_final,
    input  ready
  );
  modport sink (
    input  valid, final_count, z_real_final, z_imag_final,
    output ready
  );
endinterface

// File: src/mbe_mul.sv
// Shared fixed-point multiplier: four 32x32 partial products over cycles,
// then floor shift by FRAC_BITS and saturation. Depends on mbe_pkg.
module mbe_mul (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  mbe_pkg::val_t a,
  input  mbe_pkg::val_t b,
  output logic          done,
  output mbe_pkg::val_t result
);

  localparam logic [2:0] LAST_PP  = 3'd3;
  localparam logic [2:0] DONE_CNT = 3'd5;
  localparam logic [mbe_pkg::PROD_W-1:0] MAG_LIMIT =
    mbe_pkg::PROD_W'(1) << (mbe_pkg::VALUE_BITS - 1);
  localparam logic [mbe_pkg::PROD_W-1:0] POS_LIMIT = MAG_LIMIT - 1'b1;

  logic                        busy_r;
  logic [2:0]                  cnt_r;
  logic [mbe_pkg::MAG_W-1:0]   ma_r;
  logic [mbe_pkg::MAG_W-1:0]   mb_r;
  logic                        neg_r;
  logic [mbe_pkg::MAG_W-1:0]   pp_r;
  logic [1:0]                  sh_r;
  logic [mbe_pkg::PROD_W-1:0]  acc_r;

  logic [mbe_pkg::VALUE_BITS-1:0] mag_a;
  logic [mbe_pkg::VALUE_BITS-1:0] mag_b;
  logic [mbe_pkg::HALF_W-1:0]     a_half;
  logic [mbe_pkg::HALF_W-1:0]     b_half;
  logic [mbe_pkg::PROD_W-1:0]     q;
  logic [mbe_pkg::PROD_W-1:0]     qn;
  logic                           rem;

  // Operand magnitudes
  assign mag_a = a[mbe_pkg::VALUE_BITS-1] ? -a : a;
  assign mag_b = b[mbe_pkg::VALUE_BITS-1] ? -b : b;

  // Half select for the partial product of this cycle
  assign a_half = cnt_r[1] ? ma_r[mbe_pkg::MAG_W-1:mbe_pkg::HALF_W]
                           : ma_r[mbe_pkg::HALF_W-1:0];
  assign b_half = cnt_r[0] ? mb_r[mbe_pkg::MAG_W-1:mbe_pkg::HALF_W]
                           : mb_r[mbe_pkg::HALF_W-1:0];

  // Partial products and accumulation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      ma_r   <= mbe_pkg::MAG_W'(mag_a);
      mb_r   <= mbe_pkg::MAG_W'(mag_b);
      neg_r  <= a[mbe_pkg::VALUE_BITS-1] != b[mbe_pkg::VALUE_BITS-1];
      acc_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r <= LAST_PP) begin
        pp_r <= mbe_pkg::MAG_W'(a_half) * mbe_pkg::MAG_W'(b_half);
        sh_r <= 2'(cnt_r[1]) + 2'(cnt_r[0]);
      end
      if (cnt_r != 3'd0 && cnt_r != DONE_CNT) begin
        acc_r <= acc_r + ((mbe_pkg::PROD_W'(pp_r)) << (mbe_pkg::HALF_W * sh_r));
      end
      if (cnt_r == DONE_CNT) begin
        busy_r <= 1'b0;
      end
      cnt_r <= cnt_r + 3'd1;
    end
  end

  // Floor shift and saturation
  assign q   = acc_r >> mbe_pkg::FRAC_BITS;
  assign rem = |acc_r[mbe_pkg::FRAC_BITS-1:0];
  assign qn  = q + mbe_pkg::PROD_W'(rem);

  always_comb begin
    if (!neg_r) begin
      result = (q > POS_LIMIT) ? mbe_pkg::VAL_MAX : q[mbe_pkg::VALUE_BITS-1:0];
    end else begin
      result = (qn >= MAG_LIMIT) ? mbe_pkg::VAL_MIN : -qn[mbe_pkg::VALUE_BITS-1:0];
    end
  end

  assign done = busy_r && (cnt_r == DONE_CNT);

endmodule

// File: src/multibrot_escape_iteration.sv
// Multibrot escape iteration: z = z^power + c in saturating Q3.60 until escape
// or count limit. One shared multiplier under a sequencer. One item at a time:
// ready only when idle, so a new item is taken only after the result of the last
// one has been loaded into the output register.
// Synchronous active-low reset: idle, no result pending, registers at defaults
// (max_iterations 256, radius squared 4.0, power 2).
module multibrot_escape_iteration (
  input  logic                             clk,
  input  logic                             rst_n,
  mbe_in_if.sink                           in_ch,
  mbe_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mbe_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam logic [mbe_pkg::CNT_W-1:0] MAX_ITER_RST = 16'd256;
  localparam logic [mbe_pkg::RAD_W-1:0] RADIUS_RST   = mbe_pkg::RAD_W'(1) << 62;
  localparam logic [mbe_pkg::POW_W-1:0] POWER_RST    = 5'd2;
  localparam logic [mbe_pkg::KW-1:0]    K_START      = mbe_pkg::KW'(2);

  mbe_pkg::state_t state_r, state_nxt;

  // Configuration registers
  logic [mbe_pkg::CNT_W-1:0] max_iter_r;
  logic [mbe_pkg::RAD_W-1:0] radius_r;
  logic [mbe_pkg::POW_W-1:0] power_r;

  // Working registers
  mbe_pkg::val_t cr_r, ci_r, zr_r, zi_r, pr_r, pi_r, t3_r, t4_r;
  logic [mbe_pkg::CNT_W-1:0] count_r;
  logic [mbe_pkg::KW-1:0]    pw_r;
  logic [mbe_pkg::KW-1:0]    k_r;
  logic                      issued_r;

  // Output register
  logic                      out_valid_r;
  logic [mbe_pkg::CNT_W-1:0] out_count_r;
  mbe_pkg::val_t             out_zr_r, out_zi_r;

  // Multiplier
  logic          mul_start;
  logic          mul_done;
  logic          is_mul;
  mbe_pkg::val_t mul_a, mul_b, mul_res;

  logic                                 in_acc;
  logic                                 out_load;
  mbe_pkg::val_t                        mag;
  logic signed [mbe_pkg::CMP_W-1:0]     mag_ext, rad_ext;
  logic                                 escaped;
  logic [mbe_pkg::KW-1:0]               pw_eff;

  mbe_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (mul_res)
  );

  // Escape test on |z|^2
  assign mag     = mbe_pkg::sat_add(t3_r, t4_r);
  assign mag_ext = mbe_pkg::CMP_W'(mag);
  assign rad_ext = $signed(mbe_pkg::CMP_W'(radius_r));
  assign escaped = mag_ext > rad_ext;

  // Clamp the exponent to [2, MAX_POWER]
  always_comb begin
    if (power_r < POWER_RST) begin
      pw_eff = K_START;
    end else if (int'(power_r) > mbe_pkg::MAX_POWER) begin
      pw_eff = mbe_pkg::KW'(mbe_pkg::MAX_POWER);
    end else begin
      pw_eff = mbe_pkg::KW'(power_r);
    end
  end

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_load = (state_r == mbe_pkg::ST_FIN) && (!out_valid_r || out_ch.ready);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mbe_pkg::ST_IDLE:     if (in_ch.valid) state_nxt = mbe_pkg::ST_CHECK;
      mbe_pkg::ST_CHECK:    state_nxt = (count_r < max_iter_r) ? mbe_pkg::ST_MUL_RR
                                                               : mbe_pkg::ST_FIN;
      mbe_pkg::ST_MUL_RR:   if (mul_done) state_nxt = mbe_pkg::ST_MUL_II;
      mbe_pkg::ST_MUL_II:   if (mul_done) state_nxt = mbe_pkg::ST_ESC;
      mbe_pkg::ST_ESC:      state_nxt = escaped ? mbe_pkg::ST_FIN : mbe_pkg::ST_MUL_ZIZR;
      mbe_pkg::ST_MUL_ZIZR: if (mul_done) state_nxt = mbe_pkg::ST_PI_DBL;
      mbe_pkg::ST_PI_DBL:   state_nxt = mbe_pkg::ST_LOOP_CHK;
      mbe_pkg::ST_LOOP_CHK: state_nxt = (k_r < pw_r) ? mbe_pkg::ST_MUL_T3 : mbe_pkg::ST_UPD;
      mbe_pkg::ST_MUL_T3:   if (mul_done) state_nxt = mbe_pkg::ST_MUL_T4;
      mbe_pkg::ST_MUL_T4:   if (mul_done) state_nxt = mbe_pkg::ST_MUL_PR;
      mbe_pkg::ST_MUL_PR:   if (mul_done) state_nxt = mbe_pkg::ST_MUL_PI;
      mbe_pkg::ST_MUL_PI:   if (mul_done) state_nxt = mbe_pkg::ST_COMB;
      mbe_pkg::ST_COMB:     state_nxt = mbe_pkg::ST_LOOP_CHK;
      mbe_pkg::ST_UPD:      state_nxt = mbe_pkg::ST_CHECK;
      mbe_pkg::ST_FIN:      if (out_load) state_nxt = mbe_pkg::ST_IDLE;
      default:              state_nxt = mbe_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: ready and multiplier operands
  always_comb begin
    in_ch.ready = (state_r == mbe_pkg::ST_IDLE);
    is_mul      = 1'b1;
    mul_a       = zr_r;
    mul_b       = zr_r;
    unique case (state_r)
      mbe_pkg::ST_MUL_RR:   begin mul_a = zr_r; mul_b = zr_r; end
      mbe_pkg::ST_MUL_II:   begin mul_a = zi_r; mul_b = zi_r; end
      mbe_pkg::ST_MUL_ZIZR: begin mul_a = zi_r; mul_b = zr_r; end
      mbe_pkg::ST_MUL_T3:   begin mul_a = zi_r; mul_b = pr_r; end
      mbe_pkg::ST_MUL_T4:   begin mul_a = pi_r; mul_b = zi_r; end
      mbe_pkg::ST_MUL_PR:   begin mul_a = pr_r; mul_b = zr_r; end
      mbe_pkg::ST_MUL_PI:   begin mul_a = pi_r; mul_b = zr_r; end
      default:              is_mul = 1'b0;
    endcase
    mul_start = is_mul && !issued_r;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mbe_pkg::ST_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      max_iter_r  <= MAX_ITER_RST;
      radius_r    <= RADIUS_RST;
      power_r     <= POWER_RST;
    end else begin
      state_r <= state_nxt;
      if (mul_start) begin
        issued_r <= 1'b1;
      end else if (mul_done) begin
        issued_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      // Configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          mbe_pkg::CFG_MAX_ITER:  max_iter_r <= cfg_wdata[mbe_pkg::CNT_W-1:0];
          mbe_pkg::CFG_RADIUS_SQ: radius_r   <= cfg_wdata;
          mbe_pkg::CFG_POWER:     power_r    <= cfg_wdata[mbe_pkg::POW_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cr_r    <= in_ch.c_real[mbe_pkg::VALUE_BITS-1:0];
      ci_r    <= in_ch.c_imag[mbe_pkg::VALUE_BITS-1:0];
      zr_r    <= in_ch.z_real_start[mbe_pkg::VALUE_BITS-1:0];
      zi_r    <= in_ch.z_imag_start[mbe_pkg::VALUE_BITS-1:0];
      count_r <= in_ch.count_start;
      pw_r    <= pw_eff;
    end
    unique case (state_r)
      mbe_pkg::ST_MUL_RR:   if (mul_done) t3_r <= mul_res;
      mbe_pkg::ST_MUL_II:   if (mul_done) t4_r <= mul_res;
      mbe_pkg::ST_ESC:      pr_r <= mbe_pkg::sat_sub(t3_r, t4_r);
      mbe_pkg::ST_MUL_ZIZR: if (mul_done) pi_r <= mul_res;
      mbe_pkg::ST_PI_DBL: begin
        pi_r <= mbe_pkg::sat_add(pi_r, pi_r);
        k_r  <= K_START;
      end
      mbe_pkg::ST_MUL_T3:   if (mul_done) t3_r <= mul_res;
      mbe_pkg::ST_MUL_T4:   if (mul_done) t4_r <= mul_res;
      mbe_pkg::ST_MUL_PR:   if (mul_done) pr_r <= mul_res;
      mbe_pkg::ST_MUL_PI:   if (mul_done) pi_r <= mul_res;
      mbe_pkg::ST_COMB: begin
        pr_r <= mbe_pkg::sat_sub(pr_r, t4_r);
        pi_r <= mbe_pkg::sat_add(pi_r, t3_r);
        k_r  <= k_r + 1'b1;
      end
      mbe_pkg::ST_UPD: begin
        zr_r    <= mbe_pkg::sat_add(pr_r, cr_r);
        zi_r    <= mbe_pkg::sat_add(pi_r, ci_r);
        count_r <= count_r + 1'b1;
      end
      default: ;
    endcase
    // Result into the output register
    if (out_load) begin
      out_count_r <= count_r;
      out_zr_r    <= zr_r;
      out_zi_r    <= zi_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.final_count  = out_count_r;
  assign out_ch.z_real_final = mbe_pkg::IO_W'(out_zr_r);
  assign out_ch.z_imag_final = mbe_pkg::IO_W'(out_zi_r);

endmodule
